// ----- hw/rtl/cipb_pkg.sv -----
`default_nettype none

package cipb_pkg;

   typedef struct packed {
      logic               pattern_stamp;
      logic [6:0]         flow_percent;
      logic               pattern_kind;
      logic [7:0]         tile_size;
      logic signed [15:0] anchor_x;
      logic signed [15:0] anchor_y;
      logic [31:0]        primary_rgba;
      logic [31:0]        secondary_rgba;
   } cfg_type;

   // classified work passed from the front end to the blend engine
   typedef struct packed {
      logic        start;
      logic        outside;
      logic [31:0] dest;
      logic [31:0] src;
      logic [15:0] target;
   } item_type;

   localparam logic [2:0] REG_PATTERN_STAMP  = 3'd0;
   localparam logic [2:0] REG_FLOW_PERCENT   = 3'd1;
   localparam logic [2:0] REG_PATTERN_KIND   = 3'd2;
   localparam logic [2:0] REG_TILE_SIZE      = 3'd3;
   localparam logic [2:0] REG_ANCHOR_X       = 3'd4;
   localparam logic [2:0] REG_ANCHOR_Y       = 3'd5;
   localparam logic [2:0] REG_PRIMARY_RGBA   = 3'd6;
   localparam logic [2:0] REG_SECONDARY_RGBA = 3'd7;

   localparam logic [31:0] PRIMARY_RESET = 32'hFF00_0000;
   localparam logic [6:0]  FLOW_MAX      = 7'd100;
   localparam logic [7:0]  TILE_RESET    = 8'd8;
   localparam logic [15:0] CAP_EPS       = 16'd33;
   // ceil(2^42 / 6375): exact quotient for any 29-bit dividend
   localparam logic [29:0] TGT_RECIP     = 30'd689889649;
   localparam logic [30:0] TGT_ROUND     = 31'd12750;
   localparam logic [16:0] ONE_Q16       = 17'h10000;

endpackage

`default_nettype wire

// ----- hw/rtl/capped_incremental_paint_blend.sv -----
// Capped incremental paint blend: per-pixel brush writer for one stroke.
// Request side is queue-like: drive the item fields with req_push high; the
// item transfers on a clock edge where req_full is low. Results come out the
// same way: while rsp_empty is low the oldest result is on the rsp_ ports and
// it transfers on an edge with rsp_pop high. A start-stroke item gives no
// result; every paint item gives exactly one.
// Configuration is written through csr_we / csr_index / csr_wdata while idle.
// A paint item inside the canvas goes through the front end after its
// transfer (17-step tile remainder, tile geometry, source pick, target
// multiply, reciprocal multiply, queue push); the front end takes a new
// request only once it has pushed the last one. The blend engine does pop,
// cap read, check, 17-step incremental alpha divide, one channel per cycle
// and output load for a pixel it blends, and pop, cap read, check and output
// load for a skipped one. The two-entry queue lets the front end work ahead
// of the blend engine. The cap store has CANVAS_WIDTH * CANVAS_HEIGHT entries
// and is cleared one entry per cycle; after reset and on each start item
// req_full stays high while it is cleared. A stalled receiver holds its
// result in the output register; work behind it queues up until req_full rises.
`default_nettype none

module capped_incremental_paint_blend #(
   parameter int CANVAS_WIDTH  = 256,
   parameter int CANVAS_HEIGHT = 256,
   parameter int MAX_TILE_SIZE = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_pos_x,
   input  wire logic [7:0]  req_pos_y,
   input  wire logic [31:0] req_dest_pixel,
   input  wire logic [15:0] req_coverage,
   input  wire logic [31:0] req_dab_rgba,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [31:0]      rsp_new_pixel,
   output logic             rsp_written,
   output logic             rsp_changed,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int DEPTH = CANVAS_WIDTH * CANVAS_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int QW    = $bits(cipb_pkg::item_type) + AW;

   cipb_pkg::cfg_type  cfg_ff;
   cipb_pkg::item_type f_item, b_item;
   logic [AW-1:0]      f_addr, b_addr;
   logic               f_push, q_full, q_empty, b_pop, clearing;
   logic [QW-1:0]      q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_stamp  <= 1'b0;
         cfg_ff.flow_percent   <= cipb_pkg::FLOW_MAX;
         cfg_ff.pattern_kind   <= 1'b0;
         cfg_ff.tile_size      <= cipb_pkg::TILE_RESET;
         cfg_ff.anchor_x       <= 16'sd0;
         cfg_ff.anchor_y       <= 16'sd0;
         cfg_ff.primary_rgba   <= cipb_pkg::PRIMARY_RESET;
         cfg_ff.secondary_rgba <= 32'd0;
      end else if (csr_we) begin
         case (csr_index)
            cipb_pkg::REG_PATTERN_STAMP:  cfg_ff.pattern_stamp  <= csr_wdata[0];
            cipb_pkg::REG_FLOW_PERCENT:   cfg_ff.flow_percent   <= csr_wdata[6:0];
            cipb_pkg::REG_PATTERN_KIND:   cfg_ff.pattern_kind   <= csr_wdata[0];
            cipb_pkg::REG_TILE_SIZE:      cfg_ff.tile_size      <= csr_wdata[7:0];
            cipb_pkg::REG_ANCHOR_X:       cfg_ff.anchor_x       <= csr_wdata[15:0];
            cipb_pkg::REG_ANCHOR_Y:       cfg_ff.anchor_y       <= csr_wdata[15:0];
            cipb_pkg::REG_PRIMARY_RGBA:   cfg_ff.primary_rgba   <= csr_wdata;
            cipb_pkg::REG_SECONDARY_RGBA: cfg_ff.secondary_rgba <= csr_wdata;
            default: ;
         endcase
      end
   end

   cipb_front #(
      .CANVAS_WIDTH (CANVAS_WIDTH),
      .CANVAS_HEIGHT(CANVAS_HEIGHT),
      .MAX_TILE_SIZE(MAX_TILE_SIZE),
      .AW           (AW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .hold          (clearing),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_action    (req_action),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_dest_pixel(req_dest_pixel),
      .req_coverage  (req_coverage),
      .req_dab_rgba  (req_dab_rgba),
      .q_full        (q_full),
      .q_push        (f_push),
      .q_item        (f_item),
      .q_addr        (f_addr)
   );

   cipb_queue #(.WIDTH(QW)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_push),
      .push_data({f_item, f_addr}),
      .full     (q_full),
      .pop      (b_pop),
      .pop_data (q_out),
      .empty    (q_empty)
   );

   assign b_item = q_out[QW-1:AW];
   assign b_addr = q_out[AW-1:0];

   cipb_back #(.DEPTH(DEPTH), .AW(AW)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_pop        (b_pop),
      .q_item       (b_item),
      .q_addr       (b_addr),
      .clearing     (clearing),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_new_pixel(rsp_new_pixel),
      .rsp_written  (rsp_written),
      .rsp_changed  (rsp_changed)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/cipb_queue.sv -----
`default_nettype none

module cipb_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   logic [WIDTH-1:0] slot_ff [2];
   logic [1:0]       count_ff, count_in;
   logic             wptr_ff, rptr_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 2'd1;
      else if (do_pop && !do_push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) wptr_ff <= !wptr_ff;
         if (do_pop) rptr_ff <= !rptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/cipb_front.sv -----
`default_nettype none

module cipb_front #(
   parameter int CANVAS_WIDTH  = 256,
   parameter int CANVAS_HEIGHT = 256,
   parameter int MAX_TILE_SIZE = 128,
   parameter int AW            = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cipb_pkg::cfg_type cfg,
   input  wire logic              hold,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic              req_action,
   input  wire logic [7:0]        req_pos_x,
   input  wire logic [7:0]        req_pos_y,
   input  wire logic [31:0]       req_dest_pixel,
   input  wire logic [15:0]       req_coverage,
   input  wire logic [31:0]       req_dab_rgba,
   input  wire logic              q_full,
   output logic                   q_push,
   output cipb_pkg::item_type     q_item,
   output logic [AW-1:0]          q_addr
);

   typedef enum logic [6:0] {
      F_IDLE = 7'b0000001,
      F_MOD  = 7'b0000010,
      F_SQR  = 7'b0000100,
      F_SRC  = 7'b0001000,
      F_MUL  = 7'b0010000,
      F_DIV  = 7'b0100000,
      F_PUSH = 7'b1000000
   } fstate_type;

   localparam logic [12:0] CW     = 13'(CANVAS_WIDTH);
   localparam logic [12:0] CH     = 13'(CANVAS_HEIGHT);
   localparam logic [10:0] MAX_TS = 11'(MAX_TILE_SIZE);

   fstate_type  state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        start_ff, outside_ff;
   logic [31:0] dest_ff, dab_ff, src_ff, src_in;
   logic [15:0] cov_ff;
   logic [AW-1:0] addr_ff;
   logic [16:0] mgx_ff, mgy_ff;
   logic        negx_ff, negy_ff;
   logic [8:0]  rmx_ff, rmy_ff, rmx_in, rmy_in;
   logic [16:0] sqx_ff, sqy_ff, rr_ff;
   logic        parity_ff;
   logic [23:0] prod1_ff;
   logic [28:0] ndiv_ff;
   logic [15:0] tgt_ff;

   logic [7:0]  size;
   logic [8:0]  period;
   logic [7:0]  rad;
   logic signed [17:0] vx, vy;
   logic [17:0] ax_abs, ay_abs;
   logic [9:0]  stx, sty;
   logic [8:0]  lx, ly;
   logic signed [9:0] dx, dy;
   logic [6:0]  flow;
   logic [30:0] n_tgt;
   logic [57:0] quot;
   logic [24:0] lin;
   logic        accept;

   // clamped tile size and derived period and dot radius
   always_comb begin
      if (cfg.tile_size == 8'd0) size = 8'd1;
      else if ({3'b0, cfg.tile_size} > MAX_TS) size = MAX_TS[7:0];
      else size = cfg.tile_size;
      period = {size, 1'b0};
      rad    = (size[7:1] == 7'd0) ? 8'd1 : {1'b0, size[7:1]};
   end

   assign accept   = req_push && !req_full;
   assign req_full = (state_ff != F_IDLE) || hold;

   always_comb begin
      vx     = $signed({10'b0, req_pos_x}) - 18'(cfg.anchor_x);
      vy     = $signed({10'b0, req_pos_y}) - 18'(cfg.anchor_y);
      ax_abs = vx[17] ? 18'(-vx) : 18'(vx);
      ay_abs = vy[17] ? 18'(-vy) : 18'(vy);
      lin    = 25'(req_pos_y) * 25'(CW) + 25'(req_pos_x);
   end

   // one remainder bit per cycle for both axes
   always_comb begin
      stx    = {rmx_ff, mgx_ff[16]};
      sty    = {rmy_ff, mgy_ff[16]};
      rmx_in = (stx >= {1'b0, period}) ? 9'(stx - {1'b0, period}) : stx[8:0];
      rmy_in = (sty >= {1'b0, period}) ? 9'(sty - {1'b0, period}) : sty[8:0];
   end

   always_comb begin
      lx = (negx_ff && rmx_ff != 9'd0) ? period - rmx_ff : rmx_ff;
      ly = (negy_ff && rmy_ff != 9'd0) ? period - rmy_ff : rmy_ff;
      dx = $signed({1'b0, lx}) - $signed({2'b0, size});
      dy = $signed({1'b0, ly}) - $signed({2'b0, size});
   end

   always_comb begin
      if (!cfg.pattern_stamp) src_in = dab_ff;
      else if (cfg.pattern_kind) begin
         src_in = ({1'b0, sqx_ff} + {1'b0, sqy_ff} <= {1'b0, rr_ff}) ?
                  cfg.primary_rgba : cfg.secondary_rgba;
      end else begin
         src_in = parity_ff ? cfg.secondary_rgba : cfg.primary_rgba;
      end
      if (!cfg.pattern_stamp) flow = cipb_pkg::FLOW_MAX;
      else if (cfg.flow_percent > cipb_pkg::FLOW_MAX) flow = cipb_pkg::FLOW_MAX;
      else flow = cfg.flow_percent;
      n_tgt = 31'(prod1_ff * flow) + cipb_pkg::TGT_ROUND;
   end

   // divide by 255 * 100: quarter the sum, then multiply by the reciprocal of 6375
   always_comb begin
      quot = 58'(ndiv_ff) * 58'(cipb_pkg::TGT_RECIP);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               cnt_in = 5'd0;
               if (!req_action || {5'b0, req_pos_x} >= CW || {5'b0, req_pos_y} >= CH)
                  state_in = F_PUSH;
               else state_in = F_MOD;
            end
         end
         F_MOD: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) state_in = F_SQR;
         end
         F_SQR: state_in = F_SRC;
         F_SRC: state_in = F_MUL;
         F_MUL: state_in = F_DIV;
         F_DIV: state_in = F_PUSH;
         F_PUSH: if (!q_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         F_IDLE: begin
            start_ff   <= !req_action;
            outside_ff <= {5'b0, req_pos_x} >= CW || {5'b0, req_pos_y} >= CH;
            dest_ff    <= req_dest_pixel;
            dab_ff     <= req_dab_rgba;
            cov_ff     <= req_coverage;
            addr_ff    <= lin[AW-1:0];
            mgx_ff     <= ax_abs[16:0];
            mgy_ff     <= ay_abs[16:0];
            negx_ff    <= vx[17];
            negy_ff    <= vy[17];
            rmx_ff     <= 9'd0;
            rmy_ff     <= 9'd0;
         end
         F_MOD: begin
            rmx_ff <= rmx_in;
            rmy_ff <= rmy_in;
            mgx_ff <= {mgx_ff[15:0], 1'b0};
            mgy_ff <= {mgy_ff[15:0], 1'b0};
         end
         F_SQR: begin
            sqx_ff    <= 17'(dx * dx);
            sqy_ff    <= 17'(dy * dy);
            rr_ff     <= 17'(rad * rad);
            parity_ff <= (lx >= {1'b0, size}) ^ (ly >= {1'b0, size});
         end
         F_SRC: begin
            src_ff   <= src_in;
            prod1_ff <= cov_ff * src_in[31:24];
         end
         F_MUL: ndiv_ff <= n_tgt[30:2];
         F_DIV: tgt_ff <= quot[57:42];
         default: ;
      endcase
   end

   assign q_push = (state_ff == F_PUSH) && !q_full;
   assign q_addr = addr_ff;
   always_comb begin
      q_item.start   = start_ff;
      q_item.outside = outside_ff;
      q_item.dest    = dest_ff;
      q_item.src     = src_ff;
      q_item.target  = tgt_ff;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/cipb_back.sv -----
`default_nettype none

module cipb_back #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   output logic                    q_pop,
   input  wire cipb_pkg::item_type q_item,
   input  wire logic [AW-1:0]      q_addr,
   output logic                    clearing,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [31:0]             rsp_new_pixel,
   output logic                    rsp_written,
   output logic                    rsp_changed
);

   typedef enum logic [6:0] {
      B_CLEAR = 7'b0000001,
      B_IDLE  = 7'b0000010,
      B_READ  = 7'b0000100,
      B_CHECK = 7'b0001000,
      B_DIV   = 7'b0010000,
      B_MIX   = 7'b0100000,
      B_DONE  = 7'b1000000
   } bstate_type;

   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [15:0] cap_mem [DEPTH];

   bstate_type    state_ff, state_in;
   logic [AW-1:0] clr_ff;
   logic [4:0]    cnt_ff;
   logic [1:0]    ch_ff;
   cipb_pkg::item_type item_ff;
   logic [AW-1:0] addr_ff;
   logic [15:0]   cap_ff;
   logic          skip_ff;
   logic [16:0]   den_ff, rem_ff, quo_ff, rem_in, quo_in;
   logic [31:0]   res_ff;
   logic          valid_ff;
   logic [31:0]   px_ff;
   logic          wr_ff, chg_ff;

   logic          no_gain;
   logic [16:0]   den;
   logic [32:0]   num;
   logic [17:0]   st;
   logic [16:0]   inc, omi;
   logic [7:0]    d_b, s_b;
   logic [24:0]   mix;
   logic [7:0]    mix_b;
   logic          load_out;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [15:0]   mem_wd;

   assign clearing = (state_ff == B_CLEAR);
   assign q_pop    = (state_ff == B_IDLE) && !q_empty;
   assign load_out = (state_ff == B_DONE) && (!valid_ff || rsp_pop);

   always_comb begin
      no_gain = {1'b0, item_ff.target} <= {1'b0, cap_ff} + {1'b0, cipb_pkg::CAP_EPS};
      den     = cipb_pkg::ONE_Q16 - {1'b0, cap_ff};
      if (den < {1'b0, cipb_pkg::CAP_EPS}) den = {1'b0, cipb_pkg::CAP_EPS};
      num = {1'b0, item_ff.target - cap_ff, 16'b0} + {17'b0, den[16:1]};
   end

   // restoring divider for the incremental alpha, one bit per cycle
   always_comb begin
      st = {rem_ff, quo_ff[16]};
      if (st >= {1'b0, den_ff}) begin
         rem_in = 17'(st - {1'b0, den_ff});
         quo_in = {quo_ff[15:0], 1'b1};
      end else begin
         rem_in = st[16:0];
         quo_in = {quo_ff[15:0], 1'b0};
      end
   end

   // one channel per cycle; alpha blends toward full
   always_comb begin
      inc   = (quo_ff > cipb_pkg::ONE_Q16) ? cipb_pkg::ONE_Q16 : quo_ff;
      omi   = cipb_pkg::ONE_Q16 - inc;
      d_b   = item_ff.dest[{ch_ff, 3'b000} +: 8];
      s_b   = (ch_ff == 2'd3) ? 8'hFF : item_ff.src[{ch_ff, 3'b000} +: 8];
      mix   = 25'(s_b) * 25'(inc) + 25'(d_b) * 25'(omi) + 25'h8000;
      mix_b = mix[24] ? 8'hFF : mix[23:16];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_CLEAR: if (clr_ff == LAST) state_in = B_IDLE;
         B_IDLE: begin
            if (!q_empty) begin
               if (q_item.start) state_in = B_CLEAR;
               else if (q_item.outside) state_in = B_DONE;
               else state_in = B_READ;
            end
         end
         B_READ: state_in = B_CHECK;
         B_CHECK: state_in = no_gain ? B_DONE : B_DIV;
         B_DIV: if (cnt_ff == 5'd16) state_in = B_MIX;
         B_MIX: if (ch_ff == 2'd3) state_in = B_DONE;
         B_DONE: if (load_out) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_CLEAR) clr_ff <= clr_ff + AW'(1);
         else clr_ff <= '0;
         if (load_out) valid_ff <= 1'b1;
         else if (rsp_pop) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            item_ff <= q_item;
            addr_ff <= q_addr;
            skip_ff <= 1'b1;
         end
         B_CHECK: begin
            skip_ff <= no_gain;
            den_ff  <= den;
            rem_ff  <= {1'b0, num[32:17]};
            quo_ff  <= num[16:0];
            cnt_ff  <= 5'd0;
         end
         B_DIV: begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + 5'd1;
            ch_ff  <= 2'd0;
         end
         B_MIX: begin
            res_ff[{ch_ff, 3'b000} +: 8] <= mix_b;
            ch_ff <= ch_ff + 2'd1;
         end
         default: ;
      endcase
      if (load_out) begin
         px_ff  <= skip_ff ? item_ff.dest : res_ff;
         wr_ff  <= !skip_ff;
         chg_ff <= !skip_ff && (res_ff != item_ff.dest);
      end
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = addr_ff;
      mem_wd = item_ff.target;
      if (state_ff == B_CLEAR) begin
         mem_we = 1'b1;
         mem_wa = clr_ff;
         mem_wd = 16'd0;
      end else if (state_ff == B_CHECK && !no_gain) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) cap_mem[mem_wa] <= mem_wd;
      cap_ff <= cap_mem[addr_ff];
   end

   assign rsp_empty     = !valid_ff;
   assign rsp_new_pixel = px_ff;
   assign rsp_written   = wr_ff;
   assign rsp_changed   = chg_ff;

   a_skip_unchanged: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !wr_ff |-> !chg_ff) else $error("skipped pixel flagged changed");
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_CLEAR |-> !q_pop) else $error("queue popped during cap clear");
   a_gain_divides: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_CHECK && !no_gain |=> state_ff == B_DIV)
      else $error("cap raise did not start divider");
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_DIV |-> cnt_ff <= 5'd16) else $error("divider overran");

endmodule

`default_nettype wire
